/* rtl/frp_pkg.sv */
package frp_pkg;

	localparam int MAX_LEN    = 256;
	localparam int COUNT_W    = $clog2(MAX_LEN + 1);
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
	localparam int DEMAND_W   = FIFO_CW + 1;

	localparam logic [7:0] CH_AT = 8'h40;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_UC = 8'h43;
	localparam logic [7:0] CH_LC = 8'h63;
	localparam logic [7:0] CH_UG = 8'h47;
	localparam logic [7:0] CH_LG = 8'h67;
	localparam logic [7:0] CH_UT = 8'h54;
	localparam logic [7:0] CH_LT = 8'h74;

	typedef enum logic [2:0] {
		KIND_HDR  = 3'd0,
		KIND_WORD = 3'd1,
		KIND_DONE = 3'd2,
		KIND_DROP = 3'd3,
		KIND_ERR  = 3'd4,
		KIND_FIN  = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		PH_HDR  = 2'd0,
		PH_SEQ  = 2'd1,
		PH_SEP  = 2'd2,
		PH_QUAL = 2'd3
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] payload;
		logic [2:0]  word_index;
		logic [8:0]  read_length;
		logic [15:0] sample_out;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

/* rtl/fastq_record_parser_2bit_packer.sv */
// FASTQ record parser with 2-bit base packing. One byte word is taken per
// cycle while in_ready is high; each byte passes the input register, then
// the parse step that writes a result queue. Most bytes give zero or one
// result; a byte following a held-back CR in a header line, and the
// end-of-stream word on an open record, can give two, which then leave
// the queue one by one. The 8-entry result queue decouples the sides:
// in_ready stays high while the queue can reserve two slots for each byte in
// flight, so with out_ready high the sustained rate is one byte per cycle.
// cfg_ready is always high; sample_tag is sampled when a record completes.
module fastq_record_parser_2bit_packer import frp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_in,
	input  logic        stream_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [63:0] payload,
	output logic [2:0]  word_index,
	output logic [8:0]  read_length,
	output logic [15:0] sample_out,
	output logic        last
);

	logic [15:0]         sample_tag_q;
	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                end_s1;
	push_t               push;
	result_t             head;
	logic                not_empty;
	logic [FIFO_CW-1:0]  level;
	logic [DEMAND_W-1:0] demand;
	logic                pop;

	assign cfg_ready = 1'b1;

	// slots reserved: queue fill plus two for the byte in the register and two for a new one
	assign demand   = DEMAND_W'(level) + (valid_s1 ? DEMAND_W'(2) : DEMAND_W'(0))
		+ DEMAND_W'(2);
	assign in_ready = (demand <= DEMAND_W'(FIFO_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_tag_q <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				sample_tag_q <= cfg_data;
			end
			valid_s1 <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_in;
			end_s1  <= stream_end;
		end
	end

	frp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (valid_s1),
		.byte_s1    (byte_s1),
		.end_s1     (end_s1),
		.sample_tag (sample_tag_q),
		.push       (push)
	);

	assign pop = not_empty && out_ready;

	frp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.level     (level)
	);

	assign out_valid   = not_empty;
	assign kind        = head.kind;
	assign payload     = head.payload;
	assign word_index  = head.word_index;
	assign read_length = head.read_length;
	assign sample_out  = head.sample_out;
	assign last        = head.last;

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (DEMAND_W'(level) + DEMAND_W'(push.n) <= DEMAND_W'(FIFO_DEPTH)))
		else $error("result queue overflow");

endmodule

/* rtl/frp_fifo.sv */
module frp_fifo import frp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  push_t              push,
	input  logic               pop,
	output result_t            head,
	output logic               not_empty,
	output logic [FIFO_CW-1:0] level
);

	result_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wp_q;
	logic [FIFO_AW-1:0]   rp_q;
	logic [FIFO_CW-1:0]   level_q;
	logic [FIFO_AW-1:0]   wp_next;

	assign wp_next   = wp_q + FIFO_AW'(1);
	assign head      = mem_q[rp_q];
	assign not_empty = (level_q != '0);
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wp_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wp_next] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			level_q <= '0;
		end else begin
			wp_q    <= wp_q + FIFO_AW'(push.n);
			rp_q    <= rp_q + FIFO_AW'(pop);
			level_q <= level_q + FIFO_CW'(push.n) - FIFO_CW'(pop);
		end
	end

endmodule

/* rtl/frp_core.sv */
module frp_core import frp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [7:0]  byte_s1,
	input  logic        end_s1,
	input  logic [15:0] sample_tag,
	output push_t       push
);

	phase_t             phase_q, phase_n;
	logic               has_q, has_n;
	logic               cr_q, cr_n;
	logic               cut_q, cut_n;
	logic [63:0]        acc_q, acc_n;
	logic [COUNT_W-1:0] count_q, count_n;
	logic               halted_q, halted_n;
	push_t              p;

	function automatic logic [1:0] base_code(input logic [7:0] c);
		logic [1:0] code;
		code = 2'd0;
		if (c == CH_UC || c == CH_LC) begin
			code = 2'd1;
		end else if (c == CH_UG || c == CH_LG) begin
			code = 2'd2;
		end else if (c == CH_UT || c == CH_LT) begin
			code = 2'd3;
		end
		return code;
	endfunction

	function automatic result_t mk(input kind_t k, input logic [63:0] pl,
			input logic [2:0] wi, input logic [8:0] len, input logic [15:0] s);
		result_t r;
		r.kind        = k;
		r.payload     = pl;
		r.word_index  = wi;
		r.read_length = len;
		r.sample_out  = s;
		r.last        = 1'b0;
		return r;
	endfunction

	function automatic push_t add(input push_t pi, input result_t r);
		push_t po;
		po = pi;
		if (pi.n == 2'd0) begin
			po.r0 = r;
		end else begin
			po.r1 = r;
		end
		po.n = pi.n + 2'd1;
		return po;
	endfunction

	always_comb begin
		phase_n  = phase_q;
		has_n    = has_q;
		cr_n     = cr_q;
		cut_n    = cut_q;
		acc_n    = acc_q;
		count_n  = count_q;
		halted_n = halted_q;
		p        = '0;
		if (go && !halted_q) begin
			if (end_s1) begin
				if (phase_q == PH_QUAL && has_q) begin
					p = add(p, mk(KIND_DONE, 64'd0, 3'd0, 9'(count_q), sample_tag));
				end else if (phase_q != PH_HDR || has_q) begin
					p = add(p, mk(KIND_DROP, 64'd0, 3'd0, 9'd0, 16'd0));
				end
				p        = add(p, mk(KIND_FIN, 64'd0, 3'd0, 9'd0, 16'd0));
				halted_n = 1'b1;
				has_n    = 1'b0;
				cr_n     = 1'b0;
				acc_n    = '0;
			end else if (phase_q == PH_HDR && !has_q) begin
				if (byte_s1 != CH_AT) begin
					p        = add(p, mk(KIND_ERR, 64'd0, 3'd0, 9'd0, 16'd0));
					halted_n = 1'b1;
				end else begin
					has_n   = 1'b1;
					cut_n   = 1'b0;
					count_n = '0;
					acc_n   = '0;
				end
			end else if (byte_s1 == CH_LF) begin
				case (phase_q)
					PH_SEQ: begin
						if (count_q[4:0] != 5'd0) begin
							p = add(p, mk(KIND_WORD, acc_q, 3'(count_q >> 5), 9'd0, 16'd0));
						end
						acc_n = '0;
					end
					PH_QUAL: begin
						p = add(p, mk(KIND_DONE, 64'd0, 3'd0, 9'(count_q), sample_tag));
					end
					default: begin
					end
				endcase
				phase_n = phase_t'(phase_q + 2'd1);
				has_n   = 1'b0;
				cr_n    = 1'b0;
			end else begin
				has_n = 1'b1;
				cr_n  = (byte_s1 == CH_CR);
				case (phase_q)
					PH_HDR: begin
						// held-back cr is an ordinary header byte
						if (cr_q && !cut_q) begin
							p = add(p, mk(KIND_HDR, 64'(CH_CR), 3'd0, 9'd0, 16'd0));
						end
						if (byte_s1 != CH_CR) begin
							if (byte_s1 == CH_SP) begin
								cut_n = 1'b1;
							end else if (!cut_q) begin
								p = add(p, mk(KIND_HDR, 64'(byte_s1), 3'd0, 9'd0, 16'd0));
							end
						end
					end
					PH_SEQ: begin
						// held-back cr is a base of code zero
						if (cr_q && count_n < COUNT_W'(MAX_LEN)) begin
							count_n = count_n + COUNT_W'(1);
							if (count_n[4:0] == 5'd0) begin
								p = add(p, mk(KIND_WORD, acc_n,
									3'((count_n - COUNT_W'(1)) >> 5), 9'd0, 16'd0));
								acc_n = '0;
							end
						end
						if (byte_s1 != CH_CR && count_n < COUNT_W'(MAX_LEN)) begin
							acc_n   = acc_n | (64'(base_code(byte_s1)) << {~count_n[4:0], 1'b0});
							count_n = count_n + COUNT_W'(1);
							if (count_n[4:0] == 5'd0) begin
								p = add(p, mk(KIND_WORD, acc_n,
									3'((count_n - COUNT_W'(1)) >> 5), 9'd0, 16'd0));
								acc_n = '0;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
		if (p.n == 2'd1) begin
			p.r0.last = 1'b1;
		end else if (p.n == 2'd2) begin
			p.r1.last = 1'b1;
		end
	end

	assign push = p;

	always_ff @(posedge clk) begin
		acc_q <= acc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR;
			has_q    <= 1'b0;
			cr_q     <= 1'b0;
			cut_q    <= 1'b0;
			count_q  <= '0;
			halted_q <= 1'b0;
		end else begin
			phase_q  <= phase_n;
			has_q    <= has_n;
			cr_q     <= cr_n;
			cut_q    <= cut_n;
			count_q  <= count_n;
			halted_q <= halted_n;
		end
	end

	a_halt_holds: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halted state left without reset");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> push.n == 2'd0)
		else $error("result produced while halted");

	a_last_marks_final: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd2) |-> (push.r1.last && !push.r0.last))
		else $error("last flag not on final result of a word");

	a_count_capped: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(MAX_LEN))
		else $error("base count beyond cap");

	a_two_only_on_end_or_cr: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd2) |-> (end_s1 || $past(cr_n)))
		else $error("two results without stream end or held cr");

endmodule

/* dv/tb_fastq_record_parser_2bit_packer.sv */
`timescale 1ns / 100ps

module tb_fastq_record_parser_2bit_packer import frp_pkg::*; ();

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  byte_in;
	logic        stream_end;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  kind;
	logic [63:0] payload;
	logic [2:0]  word_index;
	logic [8:0]  read_length;
	logic [15:0] sample_out;
	logic        last;

	fastq_record_parser_2bit_packer uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.byte_in     (byte_in),
		.stream_end  (stream_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.payload     (payload),
		.word_index  (word_index),
		.read_length (read_length),
		.sample_out  (sample_out),
		.last        (last)
	);

	// parser shadow state
	phase_t      sh_phase;
	logic        sh_has_bytes;
	logic        sh_cr_held;
	logic        sh_hdr_cut;
	logic [63:0] sh_accum;
	int          sh_bases;
	logic        sh_halted;
	logic [15:0] sh_tag;
	int          step_results;

	result_t     due_results[$];
	result_t     head;

	int          n_err;
	int          n_items;
	int          n_results;
	int          n_hdr;
	int          n_words;
	int          n_records;
	int          burst_left;
	int          gap_max;
	int          noise_pct;
	int          rx_mode;
	int          rx_cyc;
	int          hold_len;
	logic        hold_req;
	string       end_how;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic flag_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		n_err++;
		$display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_results);
	endtask

	function automatic void push_result(input kind_t k, input logic [63:0] p,
		input logic [2:0] wi, input logic [8:0] rl, input logic [15:0] so);
		result_t r;
		r.kind        = k;
		r.payload     = p;
		r.word_index  = wi;
		r.read_length = rl;
		r.sample_out  = so;
		r.last        = 1'b0;
		due_results = {due_results, r};
		step_results++;
	endfunction

	function automatic logic [63:0] base_bits(input logic [7:0] c);
		case (c)
			CH_UC, CH_LC: base_bits = 64'd1;
			CH_UG, CH_LG: base_bits = 64'd2;
			CH_UT, CH_LT: base_bits = 64'd3;
			default:      base_bits = 64'd0;
		endcase
	endfunction

	function automatic void take_char(input logic [7:0] c);
		int pos;
		sh_has_bytes = 1'b1;
		if (sh_phase == PH_HDR) begin
			if (c == CH_SP)
				sh_hdr_cut = 1'b1;
			else if (!sh_hdr_cut)
				push_result(KIND_HDR, {56'd0, c}, 3'd0, 9'd0, 16'd0);
		end else if (sh_phase == PH_SEQ && sh_bases < MAX_LEN) begin
			pos = sh_bases % 32;
			sh_accum = sh_accum | (base_bits(c) << ((31 - pos) * 2));
			sh_bases++;
			if (sh_bases % 32 == 0) begin
				push_result(KIND_WORD, sh_accum, 3'(sh_bases / 32 - 1), 9'd0, 16'd0);
				sh_accum = 64'd0;
			end
		end
	endfunction

	function automatic void close_line();
		logic [1:0] nxt;
		if (sh_phase == PH_SEQ) begin
			if (sh_bases % 32 != 0)
				push_result(KIND_WORD, sh_accum, 3'(sh_bases / 32), 9'd0, 16'd0);
			sh_accum = 64'd0;
		end else if (sh_phase == PH_QUAL) begin
			push_result(KIND_DONE, 64'd0, 3'd0, 9'(sh_bases), sh_tag);
		end
		nxt = sh_phase + 2'd1;
		sh_phase = phase_t'(nxt);
		sh_has_bytes = 1'b0;
		sh_cr_held = 1'b0;
	endfunction

	function automatic void parse_byte(input logic [7:0] c, input logic se);
		step_results = 0;
		if (!sh_halted) begin
			if (se) begin
				if (sh_phase == PH_QUAL && sh_has_bytes)
					push_result(KIND_DONE, 64'd0, 3'd0, 9'(sh_bases), sh_tag);
				else if (sh_phase != PH_HDR || sh_has_bytes)
					push_result(KIND_DROP, 64'd0, 3'd0, 9'd0, 16'd0);
				push_result(KIND_FIN, 64'd0, 3'd0, 9'd0, 16'd0);
				sh_halted = 1'b1;
				sh_has_bytes = 1'b0;
				sh_cr_held = 1'b0;
				sh_accum = 64'd0;
			end else if (sh_phase == PH_HDR && !sh_has_bytes) begin
				if (c != CH_AT) begin
					push_result(KIND_ERR, 64'd0, 3'd0, 9'd0, 16'd0);
					sh_halted = 1'b1;
				end else begin
					sh_has_bytes = 1'b1;
					sh_hdr_cut = 1'b0;
					sh_bases = 0;
					sh_accum = 64'd0;
				end
			end else if (c == CH_LF) begin
				close_line();
			end else begin
				if (sh_cr_held) begin
					sh_cr_held = 1'b0;
					take_char(CH_CR);
				end
				if (c == CH_CR) begin
					sh_cr_held = 1'b1;
					sh_has_bytes = 1'b1;
				end else begin
					take_char(c);
				end
			end
		end
		if (step_results > 0)
			due_results[due_results.size() - 1].last = 1'b1;
	endfunction

	function automatic logic at_header_start();
		at_header_start = !sh_halted && sh_phase == PH_HDR && !sh_has_bytes;
	endfunction

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == CH_LF);
		text_byte = b;
	endfunction

	function automatic logic [7:0] base_byte();
		logic [7:0] b;
		case ($urandom_range(0, 19))
			0, 1:   b = 8'h41;
			2, 3:   b = 8'h61;
			4, 5:   b = CH_UC;
			6, 7:   b = CH_LC;
			8, 9:   b = CH_UG;
			10, 11: b = CH_LG;
			12, 13: b = CH_UT;
			14, 15: b = CH_LT;
			16:     b = 8'h4E;
			default: b = text_byte();
		endcase
		base_byte = b;
	endfunction

	task automatic send_word(input logic [7:0] b, input logic se);
		int gap;
		if (burst_left == 0) begin
			gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
			if (gap > 0) begin
				@(negedge clk);
				in_valid   = 1'b0;
				byte_in    = 8'($urandom);
				stream_end = 1'($urandom);
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		in_valid   = 1'b1;
		byte_in    = b;
		stream_end = se;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		n_items++;
		parse_byte(b, se);
	endtask

	// noise may hit any byte, but a header never opens without '@' here
	task automatic put_byte(input logic [7:0] b);
		logic [7:0] v;
		v = b;
		if (noise_pct > 0 && $urandom_range(0, 99) < noise_pct)
			v = 8'($urandom);
		if (at_header_start() && v != CH_AT)
			v = CH_AT;
		send_word(v, 1'b0);
	endtask

	task automatic put_eol();
		if ($urandom_range(0, 2) == 0)
			put_byte(CH_CR);
		put_byte(CH_LF);
	endtask

	task automatic put_header();
		int n;
		put_byte(CH_AT);
		n = $urandom_range(1, 10);
		for (int i = 0; i < n; i++)
			put_byte(($urandom_range(0, 9) < 7) ? 8'($urandom_range(33, 126)) : text_byte());
		if ($urandom_range(0, 1)) begin
			put_byte(CH_SP);
			n = $urandom_range(0, 6);
			for (int i = 0; i < n; i++)
				put_byte(text_byte());
		end
		put_eol();
	endtask

	task automatic put_sequence(input int len);
		for (int i = 0; i < len; i++)
			put_byte(base_byte());
		put_eol();
	endtask

	task automatic put_separator();
		put_byte(8'h2B);
		if ($urandom_range(0, 3) == 0)
			put_byte(8'($urandom_range(33, 126)));
		put_eol();
	endtask

	task automatic put_quality(input int len, input logic with_eol);
		for (int i = 0; i < len; i++)
			put_byte(($urandom_range(0, 9) < 8) ? 8'($urandom_range(33, 126)) : text_byte());
		if (with_eol)
			put_eol();
	endtask

	task automatic put_record(input int len);
		int qlen;
		qlen = ($urandom_range(0, 9) < 7) ? len : $urandom_range(0, 5);
		put_header();
		put_sequence(len);
		put_separator();
		put_quality(qlen, 1'b1);
	endtask

	function automatic int pick_read_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 16)
			pick_read_len = $urandom_range(0, 40);
		else if (r < 19)
			pick_read_len = $urandom_range(41, 100);
		else
			pick_read_len = 32 * $urandom_range(1, 3);
	endfunction

	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_tag(input logic [15:0] v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sh_tag = v;
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_data  = 16'($urandom);
	endtask

	task automatic test_directed();
		logic [7:0] dir [0:26] = '{CH_AT, 8'hFF, 8'h00, CH_CR, 8'h78, CH_SP, 8'h7A, CH_CR,
			CH_LF, 8'h61, CH_UC, CH_LG, CH_UT, 8'h41, CH_LC, CH_UG, CH_LT, CH_CR, 8'h6E,
			CH_LF, 8'h2B, CH_LF, 8'hFF, 8'h00, CH_CR, CH_CR, CH_LF};
		gap_max = 0;
		noise_pct = 0;
		rx_mode = 0;
		write_tag(16'hA5C3);
		foreach (dir[i])
			put_byte(dir[i]);
		wait_idle();
	endtask

	task automatic test_records(input logic [15:0] tag, input int gmax, input int rmode,
		input int noise, input int n_bytes);
		int start;
		write_tag(tag);
		gap_max = gmax;
		rx_mode = rmode;
		noise_pct = noise;
		start = n_items;
		while (n_items - start < n_bytes)
			put_record(pick_read_len());
		wait_idle();
	endtask

	task automatic test_long_reads();
		int lens [0:3] = '{31, 33, 256, 290};
		write_tag(16'hFFFF);
		gap_max = 3;
		rx_mode = 1;
		noise_pct = 0;
		foreach (lens[i]) begin
			put_header();
			put_sequence(lens[i]);
			put_separator();
			put_quality($urandom_range(1, 4), 1'b1);
		end
		wait_idle();
	endtask

	task automatic test_backpressure();
		int start;
		write_tag(16'h0000);
		gap_max = 0;
		rx_mode = 0;
		noise_pct = 0;
		hold_len = 400;
		@(posedge clk);
		hold_req = 1'b1;
		start = n_items;
		while (n_items - start < 100)
			put_record(pick_read_len());
		wait_idle();
		gap_max = 6;
		rx_mode = 2;
		start = n_items;
		while (n_items - start < 100)
			put_record(pick_read_len());
		wait_idle();
	endtask

	task automatic test_stream_stop();
		logic [7:0] b;
		write_tag(16'($urandom));
		gap_max = 4;
		rx_mode = 1;
		noise_pct = 0;
		while (!at_header_start())
			put_byte(CH_LF);
		case ($urandom_range(0, 3))
			0: begin
				end_how = "format error";
				do b = 8'($urandom); while (b == CH_AT);
				send_word(b, 1'b0);
			end
			1: begin
				end_how = "end of stream with no open record";
				send_word(8'($urandom), 1'b1);
			end
			2: begin
				end_how = "end of stream inside quality line";
				put_header();
				put_sequence(pick_read_len());
				put_separator();
				put_quality($urandom_range(1, 5), 1'b0);
				send_word(8'($urandom), 1'b1);
			end
			default: begin
				end_how = "end of stream inside sequence line";
				put_header();
				for (int i = $urandom_range(0, 40); i > 0; i--)
					put_byte(base_byte());
				send_word(8'($urandom), 1'b1);
			end
		endcase
		// block is halted now: nothing more may come out
		for (int i = 0; i < 12; i++)
			send_word(8'($urandom), 1'($urandom));
		wait_idle();
	endtask

	initial begin
		out_ready = 1'b0;
		rx_cyc = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			rx_cyc++;
			if (hold_req) begin
				out_ready = 1'b0;
				for (int i = 1; i < hold_len; i++)
					@(negedge clk);
				hold_req = 1'b0;
			end else begin
				case (rx_mode)
					0: out_ready = 1'b1;
					1: out_ready = ($urandom_range(0, 9) < 7);
					2: out_ready = (rx_cyc % 5 != 0) && (rx_cyc % 13 > 3);
					default: out_ready = ($urandom_range(0, 9) < 3);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				flag_mismatch("unexpected result kind", 64'(kind), 64'd0);
			end else begin
				head = due_results.pop_front();
				n_results++;
				if (head.kind == KIND_HDR)  n_hdr++;
				if (head.kind == KIND_WORD) n_words++;
				if (head.kind == KIND_DONE) n_records++;
				if (kind !== head.kind)
					flag_mismatch("kind", 64'(kind), 64'(head.kind));
				if (payload !== head.payload)
					flag_mismatch("payload", payload, head.payload);
				if (word_index !== head.word_index)
					flag_mismatch("word_index", 64'(word_index), 64'(head.word_index));
				if (read_length !== head.read_length)
					flag_mismatch("read_length", 64'(read_length), 64'(head.read_length));
				if (sample_out !== head.sample_out)
					flag_mismatch("sample_out", 64'(sample_out), 64'(head.sample_out));
				if (last !== head.last)
					flag_mismatch("last", 64'(last), 64'(head.last));
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = 16'd0;
		in_valid   = 1'b0;
		byte_in    = 8'd0;
		stream_end = 1'b0;
		hold_req   = 1'b0;
		hold_len   = 0;
		sh_phase     = PH_HDR;
		sh_has_bytes = 1'b0;
		sh_cr_held   = 1'b0;
		sh_hdr_cut   = 1'b0;
		sh_accum     = 64'd0;
		sh_bases     = 0;
		sh_halted    = 1'b0;
		sh_tag       = 16'd0;
		n_err = 0;
		n_items = 0;
		n_results = 0;
		n_hdr = 0;
		n_words = 0;
		n_records = 0;
		burst_left = 0;
		gap_max = 0;
		noise_pct = 0;
		rx_mode = 0;
		end_how = "";
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (4) @(posedge clk);

		test_directed();
		test_records(16'hFFFF, 0, 0, 0, 120);
		test_records(16'h0000, 8, 1, 2, 120);
		test_records(16'($urandom), 3, 2, 0, 120);
		test_records(16'($urandom), 12, 3, 4, 100);
		test_long_reads();
		test_backpressure();
		test_stream_stop();

		repeat (10) @(posedge clk);
		$display("covered %0d input words and %0d results: %0d header bytes, %0d sequence words",
			n_items, n_results, n_hdr, n_words);
		$display("%0d records completed; stream closed by %s", n_records, end_how);
		if (n_err == 0 && due_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
